// ----- rtl/hcfc_pkg.sv -----
// Shared types, constants and functions of the hex command frame checker.
// Used by every module under rtl; depends on nothing.
package hcfc_pkg;

    localparam int CharW      = 8;
    localparam int StoreDepth = 10;
    localparam int CountW     = 4;
    localparam int CrcW       = 8;
    localparam int OutDataW   = 40;
    localparam int OutUserW   = 4;

    localparam logic [CountW-1:0] CountMax      = 4'd15;
    localparam logic [CountW-1:0] LenShort      = 4'd5;
    localparam logic [CountW-1:0] LenLong       = 4'd7;
    localparam logic [CountW-1:0] LenShortCrc   = 4'd8;
    localparam logic [CountW-1:0] LenLongCrc    = 4'd10;
    localparam logic [CountW-1:0] StoreLimit    = 4'd10;
    localparam logic [CrcW-1:0]   CrcPoly       = 8'h8C;
    localparam logic [CharW-1:0]  ColonChar     = 8'h3A;
    localparam logic [CharW-1:0]  NulChar       = 8'h00;

    typedef logic [CharW-1:0] char_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_LEN,
        ST_NO_COLON,
        ST_CRC_BAD
    } status_t;

    typedef enum logic [1:0] {
        FMT_SHORT,
        FMT_LONG,
        FMT_SHORT_CRC,
        FMT_LONG_CRC
    } format_t;

    // One character word held in the input stage
    typedef struct packed {
        char_t char_code;
        logic  last;
    } in_word_t;

    // Handshake between input stage and frame core
    typedef struct packed {
        logic     valid;
        in_word_t word;
    } in_stage_t;

    typedef struct packed {
        status_t     status;
        format_t     frame_format;
        logic [15:0] unit_address;
        logic [7:0]  pin_code;
        logic [3:0]  command_code;
        logic [7:0]  crc_received;
    } result_t;

    // Dallas/Maxim CRC-8, reflected, one byte per call
    function automatic logic [CrcW-1:0] crc8_update(input logic [CrcW-1:0] crc,
                                                    input char_t byte_in);
        logic [CrcW-1:0] c;
        c = crc ^ byte_in;
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic is_hex(input char_t c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_value(input char_t c);
        logic [3:0] v;
        if ((c >= 8'h30) && (c <= 8'h39))
            v = c[3:0];
        else
            v = c[3:0] + 4'd9;   // 'a'..'f' and 'A'..'F' end in 1..6
        return v;
    endfunction

    // Hex value of up to four characters, chars[0] first; stops at a non-hex digit
    function automatic logic [15:0] hex_field(input char_t [3:0] chars,
                                              input logic [2:0] len);
        logic [15:0] v;
        logic        run;
        v   = '0;
        run = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (run && (3'(i) < len) && is_hex(chars[i]))
                v = {v[11:0], hex_value(chars[i])};
            else
                run = 1'b0;
        end
        return v;
    endfunction

endpackage

// ----- rtl/hcfc_in_stage.sv -----
// Input register of the hex command frame checker: takes one character word.
// Depends on hcfc_pkg.
module hcfc_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hcfc_pkg::char_t       s_char,
    input  logic                  s_last,
    input  logic                  advance,
    output hcfc_pkg::in_stage_t   stage
);
    import hcfc_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    // Room when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_valid && s_ready)
            valid_reg <= 1'b1;
        else if (advance)
            valid_reg <= 1'b0;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            word_reg.char_code <= s_char;
            word_reg.last      <= s_last;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

// ----- rtl/hcfc_frame_core.sv -----
// Frame core: character store, CRC, length tracking, field decode, result register.
// Depends on hcfc_pkg.
module hcfc_frame_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcfc_pkg::in_stage_t  stage,
    output logic                 advance,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcfc_pkg::result_t    result
);
    import hcfc_pkg::*;

    char_t           store_reg [StoreDepth];
    logic [CountW-1:0] count_reg;
    logic            zero_seen_reg;
    logic [CrcW-1:0] crc_reg;
    logic [CrcW-1:0] crc_five_reg;
    logic [CrcW-1:0] crc_seven_reg;
    logic            out_valid_reg;
    result_t         result_reg;

    char_t           store_next [StoreDepth];
    logic [CountW-1:0] count_next;
    logic            zero_seen_next;
    logic [CrcW-1:0] crc_next;
    logic [CrcW-1:0] crc_five_next;
    logic [CrcW-1:0] crc_seven_next;
    logic            take_char;
    result_t         result_next;

    char_t           c;
    logic [15:0]     addr_val;
    logic [7:0]      pin_one;
    logic [7:0]      pin_two;
    logic [3:0]      cmd_val;
    logic [7:0]      rr_short;
    logic [7:0]      rr_long;

    // A word not ending a string needs no room in the result register
    assign advance = stage.valid && (!stage.word.last || !out_valid_reg || out_ready);

    assign c         = stage.word.char_code;
    assign take_char = (c != NulChar) && !zero_seen_reg;

    // Per-string state after this character
    always_comb
    begin
        for (int i = 0; i < StoreDepth; i++)
            store_next[i] = store_reg[i];
        count_next     = count_reg;
        zero_seen_next = zero_seen_reg || (c == NulChar);
        crc_next       = crc_reg;
        crc_five_next  = crc_five_reg;
        crc_seven_next = crc_seven_reg;
        if (take_char)
        begin
            if (count_reg < StoreLimit)
                store_next[count_reg] = c;
            if (count_reg != CountMax)
            begin
                count_next = count_reg + 4'd1;
                crc_next   = crc8_update(crc_reg, c);
                if (count_next == LenShort)
                    crc_five_next = crc_next;
                if (count_next == LenLong)
                    crc_seven_next = crc_next;
            end
        end
    end

    // Fixed field decode on the store including this character
    always_comb
    begin
        addr_val = hex_field({store_next[3], store_next[2], store_next[1], store_next[0]},
                             3'd4);
        pin_one  = 8'(hex_field({NulChar, NulChar, NulChar, store_next[4]}, 3'd1));
        pin_two  = 8'(hex_field({NulChar, NulChar, store_next[5], store_next[4]}, 3'd2));
        cmd_val  = 4'(hex_field({NulChar, NulChar, NulChar, store_next[6]}, 3'd1));
        rr_short = 8'(hex_field({NulChar, NulChar, store_next[7], store_next[6]}, 3'd2));
        rr_long  = 8'(hex_field({NulChar, NulChar, store_next[9], store_next[8]}, 3'd2));
    end

    // Frame format and status by length
    always_comb
    begin
        result_next = '0;
        case (count_next)
            LenShort:
            begin
                result_next.frame_format = FMT_SHORT;
                result_next.unit_address = addr_val;
                result_next.pin_code     = pin_one;
            end
            LenLong:
            begin
                result_next.frame_format = FMT_LONG;
                result_next.unit_address = addr_val;
                result_next.pin_code     = pin_two;
                result_next.command_code = cmd_val;
            end
            LenShortCrc:
            begin
                result_next.frame_format = FMT_SHORT_CRC;
                if (store_next[5] != ColonChar)
                    result_next.status = ST_NO_COLON;
                else
                begin
                    result_next.unit_address = addr_val;
                    result_next.pin_code     = pin_one;
                    result_next.crc_received = rr_short;
                    if (rr_short != crc_five_reg)
                        result_next.status = ST_CRC_BAD;
                end
            end
            LenLongCrc:
            begin
                result_next.frame_format = FMT_LONG_CRC;
                if (store_next[7] != ColonChar)
                    result_next.status = ST_NO_COLON;
                else
                begin
                    result_next.unit_address = addr_val;
                    result_next.pin_code     = pin_two;
                    result_next.command_code = cmd_val;
                    result_next.crc_received = rr_long;
                    if (rr_long != crc_seven_reg)
                        result_next.status = ST_CRC_BAD;
                end
            end
            default:
                result_next.status = ST_BAD_LEN;
        endcase
    end

    // Control state; clears after the last character of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            zero_seen_reg <= 1'b0;
            crc_reg       <= '0;
            crc_five_reg  <= '0;
            crc_seven_reg <= '0;
        end
        else if (advance)
        begin
            if (stage.word.last)
            begin
                count_reg     <= '0;
                zero_seen_reg <= 1'b0;
                crc_reg       <= '0;
                crc_five_reg  <= '0;
                crc_seven_reg <= '0;
            end
            else
            begin
                count_reg     <= count_next;
                zero_seen_reg <= zero_seen_next;
                crc_reg       <= crc_next;
                crc_five_reg  <= crc_five_next;
                crc_seven_reg <= crc_seven_next;
            end
        end
    end

    // Character store, undefined until written
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < StoreDepth; i++)
                store_reg[i] <= store_next[i];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && stage.word.last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.word.last)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef ASSERT_OFF
    // String state is cleared after the last character
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage.word.last |=> (count_reg == '0) && !zero_seen_reg && (crc_reg == '0))
        else $error("string state not cleared after last word");

    // Bad length reports no fields
    a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.status == ST_BAD_LEN) |->
        (result_reg.unit_address == '0) && (result_reg.pin_code == '0) &&
        (result_reg.command_code == '0) && (result_reg.crc_received == '0) &&
        (result_reg.frame_format == FMT_SHORT))
        else $error("bad length result carries fields");

    // Colon and CRC checks only apply to the CRC forms
    a_colon_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((result_reg.status == ST_NO_COLON) ||
                          (result_reg.status == ST_CRC_BAD)) |->
        ((result_reg.frame_format == FMT_SHORT_CRC) ||
         (result_reg.frame_format == FMT_LONG_CRC)))
        else $error("colon or crc status on a short form");

    // A waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(advance && stage.word.last))
        else $error("result overwritten while stalled");
`endif

endmodule

// ----- rtl/hex_command_frame_checker_top.sv -----
// Hex command frame checker, top level.
// Input: one ASCII character per word on s_axis, tlast on the final character.
// Characters up to the first zero byte are counted, stored and run through a
// Dallas/Maxim CRC-8. On the tlast word one result word leaves on m_axis with
// the frame format, status and hex decoded fields; other words give no output.
// A tlast word accepted on s_axis passes the input register, then the result
// register, before m_axis_tvalid rises. Throughput: one character per cycle
// while s_axis_tready is high, set by the combinational CRC byte update and fixed-field decode.
// When m_axis_tready is low, a waiting result holds; non-final characters still
// flow in, and s_axis_tready drops only when a tlast word finds the result
// register full.
// Reset (rst_n low, asynchronous) empties both registers and clears the count,
// zero mark and CRCs; the character store is not cleared.
// Depends on hcfc_pkg, hcfc_in_stage and hcfc_frame_core.
module hex_command_frame_checker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
    input  logic                          s_axis_tlast,   // end_of_string
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hcfc_pkg::OutDataW-1:0] m_axis_tdata,   // [15:0] unit_address,
                                                          // [23:16] pin_code,
                                                          // [27:24] command_code,
                                                          // [35:28] crc_received,
                                                          // [39:36] zero
    output logic [hcfc_pkg::OutUserW-1:0] m_axis_tuser    // [1:0] status,
                                                          // [3:2] frame_format
);
    import hcfc_pkg::*;

    in_stage_t stage;
    logic      advance;
    result_t   result;

    hcfc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_char  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .advance (advance),
        .stage   (stage)
    );

    hcfc_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // Pack the result word
    assign m_axis_tdata = {4'b0000, result.crc_received, result.command_code,
                           result.pin_code, result.unit_address};
    assign m_axis_tuser = {result.frame_format, result.status};

endmodule
